// ===== rtl/mnhf_pkg.sv =====
// shared constants, types and helpers for the harmonic frame normalizer
package mnhf_pkg;

   localparam int PointsDefault = 64;
   localparam int MaxPoints     = 64;
   localparam int IdxW          = 8;
   localparam int AmpW          = 32;
   localparam int ValW          = 31;
   localparam int RatioW        = 32;
   localparam int QueueDepth    = 4;

   typedef struct packed {
      logic [IdxW-1:0] index;
      logic [ValW-1:0] first;
      logic [ValW-1:0] second;
   } sample_type;

   function automatic logic [ValW-1:0] clamp_amp(input logic [AmpW-1:0] raw);
      return raw[AmpW-1] ? '0 : raw[ValW-1:0];
   endfunction

endpackage

// ===== rtl/mnhf_ram.sv =====
// generic single write port ram with registered read
module mnhf_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/mnhf_front.sv =====
// input stage: range filter, clamp and sample queue
module mnhf_front #(
   parameter int Points = mnhf_pkg::PointsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [mnhf_pkg::IdxW-1:0] in_index,
   input  logic [mnhf_pkg::AmpW-1:0] in_first,
   input  logic [mnhf_pkg::AmpW-1:0] in_second,
   output logic                   q_valid,
   input  logic                   q_ready,
   output mnhf_pkg::sample_type   q_data
);
   import mnhf_pkg::*;
   localparam int QW = $clog2(QueueDepth);

   sample_type   buf_ff [QueueDepth];
   logic [QW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QW:0]   cnt_ff, cnt_in;
   logic          push, pop, keep;

   assign keep     = {1'b0, in_index} < (IdxW+1)'(Points);
   assign in_ready = cnt_ff != (QW+1)'(QueueDepth);
   assign push     = in_valid && in_ready && keep;
   assign q_valid  = cnt_ff != '0;
   assign pop      = q_valid && q_ready;
   assign q_data   = buf_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (QW+1)'(push) - (QW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wp_ff] <= '{index: in_index, first: clamp_amp(in_first),
                            second: clamp_amp(in_second)};
      end
   end
endmodule

// ===== rtl/mnhf_divider.sv =====
// restoring divider, one quotient bit per cycle
module mnhf_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [47:0] quotient
);
   logic [47:0] q_ff, q_in;
   logic [33:0] r_ff, r_in;
   logic [5:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] d_ff, d_in;
   logic [33:0] sh;

   always_comb begin
      q_in = q_ff; r_in = r_ff; n_in = n_ff; d_in = d_ff;
      busy_in = busy_ff; done_in = 1'b0;
      sh = {r_ff[32:0], q_ff[47]};
      if (start) begin
         q_in = dividend; r_in = '0; n_in = 6'd48; d_in = divisor; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[46:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[46:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; n_ff <= n_in; d_ff <= d_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule

// ===== rtl/mnhf_back.sv =====
// frame store, median selection, ratio division and result output
module mnhf_back #(
   parameter int Points = mnhf_pkg::PointsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [mnhf_pkg::ValW-1:0] min_ref,
   input  logic                      q_valid,
   output logic                      q_ready,
   input  mnhf_pkg::sample_type      q_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [5:0]                out_index,
   output logic [mnhf_pkg::ValW-1:0] out_first,
   output logic [mnhf_pkg::ValW-1:0] out_second,
   output logic [31:0]               out_ratio,
   output logic                      out_ref,
   output logic [31:0]               out_fs,
   output logic                      out_last
);
   import mnhf_pkg::*;
   localparam int AW = $clog2(MaxPoints);
   localparam int CW = AW + 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CNT   = 4'd1;
   localparam logic [3:0] S_SEL   = 4'd2;
   localparam logic [3:0] S_SELW  = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_DIVW  = 4'd5;
   localparam logic [3:0] S_PEAK  = 4'd6;
   localparam logic [3:0] S_EMIT  = 4'd7;
   localparam logic [3:0] S_EMITW = 4'd8;
   localparam logic [3:0] S_STORE = 4'd9;
   localparam logic [3:0] S_FS    = 4'd10;

   logic [3:0]      st_ff, st_in;
   logic [MaxPoints-1:0] fill_ff, fill_in;
   logic [CW-1:0]   i_ff, i_in, j_ff, j_in;
   logic [CW-1:0]   cnt_ff, cnt_in, less_ff, less_in, eq_ff, eq_in;
   logic [1:0]      pick_ff, pick_in;
   logic [CW-1:0]   rank_ff, rank_in;
   logic [ValW-1:0] cand_ff, cand_in, m0_ff, m0_in;
   logic [32:0]     den_ff, den_in;
   logic [31:0]     peak_ff, peak_in, fs_ff, fs_in;
   logic [27:0]     q25_ff, q25_in;
   logic            start;
   logic [47:0]     quot;
   logic            ddone;
   logic            ov_ff, ov_in;
   logic [5:0]      oidx_ff, oidx_in;
   logic [ValW-1:0] of_ff, of_in, os_ff, os_in;
   logic [31:0]     or_ff, or_in;
   logic            ol_ff, ol_in;
   logic [64:0]     recip;
   logic [31:0]     rem25;
   logic [32:0]     fs_sum;

   logic              wr_en;
   logic [AW-1:0]     rd_addr;
   logic [ValW-1:0]   rf, rs;
   logic              rat_we;
   logic [RatioW-1:0] rat_wd, rr;
   logic              complete;

   assign complete = &fill_ff[Points-1:0];

   mnhf_ram #(.Width(ValW), .Depth(MaxPoints)) u_first (
      .clock, .wr_en, .wr_addr(q_data.index[AW-1:0]), .wr_data(q_data.first),
      .rd_addr, .rd_data(rf));
   mnhf_ram #(.Width(ValW), .Depth(MaxPoints)) u_second (
      .clock, .wr_en, .wr_addr(q_data.index[AW-1:0]), .wr_data(q_data.second),
      .rd_addr, .rd_data(rs));
   mnhf_ram #(.Width(RatioW), .Depth(MaxPoints)) u_ratio (
      .clock, .wr_en(rat_we), .wr_addr(i_ff[AW-1:0]), .wr_data(rat_wd),
      .rd_addr, .rd_data(rr));

   mnhf_divider u_div (
      .clock, .reset, .start, .dividend({rs, 17'd0}), .divisor(den_ff),
      .done(ddone), .quotient(quot));

   // peak / 25 by reciprocal multiplication, exact for 32-bit peaks
   assign recip  = 65'(peak_ff) * 65'(33'd5497558139);
   assign rem25  = peak_ff - 32'(q25_ff) * 32'd25;
   // peak * 1.08 = peak + floor(2 * peak / 25)
   assign fs_sum = 33'(peak_ff) + 33'({q25_ff, 1'b0}) + 33'(rem25 >= 32'd13);

   assign rat_we = (st_ff == S_DIVW) && (den_ff == '0 || ddone);
   assign rat_wd = (den_ff == '0) ? '0 : ((quot[47:32] != '0) ? '1 : quot[31:0]);

   always_comb begin
      st_in = st_ff; fill_in = fill_ff; i_in = i_ff; j_in = j_ff;
      cnt_in = cnt_ff; less_in = less_ff; eq_in = eq_ff; pick_in = pick_ff;
      rank_in = rank_ff; cand_in = cand_ff; m0_in = m0_ff; den_in = den_ff;
      peak_in = peak_ff; fs_in = fs_ff; q25_in = q25_ff; ov_in = ov_ff;
      oidx_in = oidx_ff;
      of_in = of_ff; os_in = os_ff; or_in = or_ff; ol_in = ol_ff;
      q_ready = 1'b0; wr_en = 1'b0; start = 1'b0;
      rd_addr = i_ff[AW-1:0];
      if (ov_ff && out_ready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            // the last beat of a frame must leave before the next publish
            if (q_valid && !ov_ff) begin
               if (q_data.index == '0 && complete) begin
                  i_in = '0; cnt_in = '0; st_in = S_CNT;
               end else begin
                  st_in = S_STORE;
               end
            end
         end
         S_STORE: begin
            q_ready = 1'b1; wr_en = 1'b1;
            if (q_data.index == '0) fill_in = '0;
            fill_in[q_data.index[AW-1:0]] = 1'b1;
            st_in = S_IDLE;
         end
         S_CNT: begin
            // read latency: index i_ff-1 data available while i_ff advances
            if (i_ff != '0 && rf > min_ref) cnt_in = cnt_ff + 1'b1;
            if (i_ff == CW'(Points)) begin
               cnt_in = (i_ff != '0 && rf > min_ref) ? cnt_ff + 1'b1 : cnt_ff;
               pick_in = '0; den_in = '0; st_in = S_SEL;
               rank_in = ((cnt_in - 1'b1) >> 1);
               if (cnt_in == '0) begin
                  i_in = '0; peak_in = '0; st_in = S_DIV;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_SEL: begin
            // pick candidate j, scan all for rank
            rd_addr = j_ff[AW-1:0];
            st_in = S_SELW; i_in = '0; less_in = '0; eq_in = '0;
         end
         S_SELW: begin
            if (i_ff == '0) begin
               cand_in = rf;
            end else if (rf > min_ref) begin
               if (rf < cand_ff) less_in = less_ff + 1'b1;
               else if (rf == cand_ff) eq_in = eq_ff + 1'b1;
            end
            if (i_ff == CW'(Points)) begin
               i_in = '0;
               if (cand_ff > min_ref && less_in <= rank_ff &&
                   rank_ff < less_in + eq_in) begin
                  if (pick_ff == 2'd0 && !cnt_ff[0]) begin
                     m0_in = cand_ff; pick_in = 2'd1;
                     rank_in = rank_ff + 1'b1; j_in = '0; st_in = S_SEL;
                  end else begin
                     den_in = (pick_ff == 2'd1) ? 33'(m0_ff) + 33'(cand_ff)
                                                : {1'b0, cand_ff, 1'b0};
                     peak_in = '0; j_in = '0; st_in = S_DIV;
                  end
               end else begin
                  j_in = j_ff + 1'b1; st_in = S_SEL;
               end
            end else begin
               rd_addr = i_ff[AW-1:0];
               i_in = i_ff + 1'b1;
            end
         end
         S_DIV: begin
            rd_addr = i_ff[AW-1:0];
            st_in = S_DIVW;
         end
         S_DIVW: begin
            if (den_ff == '0) begin
               i_in = i_ff + 1'b1;
               st_in = (i_ff == CW'(Points - 1)) ? S_PEAK : S_DIV;
            end else if (!start && j_ff == '0) begin
               start = 1'b1; j_in = 1'b1;
            end else if (ddone) begin
               j_in = '0;
               if (quot[47:32] == '0 ? quot[31:0] > peak_ff : 1'b1)
                  peak_in = (quot[47:32] != '0) ? '1 : quot[31:0];
               i_in = i_ff + 1'b1;
               st_in = (i_ff == CW'(Points - 1)) ? S_PEAK : S_DIV;
            end
         end
         S_PEAK: begin
            if (peak_ff == '0) begin
               fs_in = 32'd65536;
               i_in = '0; j_in = '0; st_in = S_EMIT;
            end else begin
               q25_in = recip[64:37];
               st_in = S_FS;
            end
         end
         S_FS: begin
            fs_in = fs_sum[32] ? '1 : fs_sum[31:0];
            i_in = '0; j_in = '0; st_in = S_EMIT;
         end
         S_EMIT: begin
            rd_addr = i_ff[AW-1:0];
            if (!ov_ff || out_ready) st_in = S_EMITW;
         end
         S_EMITW: begin
            rd_addr = i_ff[AW-1:0];
            if (!ov_in) begin
               ov_in = 1'b1; oidx_in = i_ff[5:0]; of_in = rf; os_in = rs;
               or_in = rr;
               ol_in = i_ff == CW'(Points - 1);
               i_in = i_ff + 1'b1;
               st_in = ol_in ? S_STORE : S_EMIT;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; fill_ff <= '0; ov_ff <= 1'b0; j_ff <= '0;
      end else begin
         st_ff <= st_in; fill_ff <= fill_in; ov_ff <= ov_in; j_ff <= j_in;
      end
      i_ff <= i_in; cnt_ff <= cnt_in; less_ff <= less_in; eq_ff <= eq_in;
      pick_ff <= pick_in; rank_ff <= rank_in; cand_ff <= cand_in; m0_ff <= m0_in;
      den_ff <= den_in; peak_ff <= peak_in; fs_ff <= fs_in; q25_ff <= q25_in;
      oidx_ff <= oidx_in; of_ff <= of_in; os_ff <= os_in; or_ff <= or_in;
      ol_ff <= ol_in;
   end

   assign out_valid  = ov_ff;
   assign out_index  = oidx_ff;
   assign out_first  = of_ff;
   assign out_second = os_ff;
   assign out_ratio  = or_ff;
   assign out_ref    = den_ff != '0;
   assign out_fs     = fs_ff;
   assign out_last   = ol_ff;
endmodule

// ===== rtl/median_normalized_harmonic_frame_top.sv =====
// top level of the median-normalized harmonic frame builder
//
// samples enter on the req_ stream (index, first and second amplitude).
// indices at or beyond the frame size are dropped in the front queue.
// index 0 closes the pending frame; a complete frame is published on
// the rsp_ stream as one beat per point in point order, tlast on the
// final point. incomplete frames are dropped silently.
// publishing runs a count pass, a median search driven by the single ram
// read port, then the 48-step serial division for each point, a full-scale
// step, then Points output beats. the median search and the divider set the
// frame cost.
// the front queue of four samples keeps accepting while the back end works.
// reset clears the fill map, queue and output register; stored amplitudes
// are not cleared. when rsp_tready is low the output beat holds and the
// back end waits; the queue then fills and req_tready drops.
// the user must write min_reference through csr_ only while the block is idle; the block itself does not enforce this.
module median_normalized_harmonic_frame_top #(
   parameter int Points = mnhf_pkg::PointsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [30:0]  csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,  // point_index, first_amp, second_amp
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,  // out_index, out_first, out_second, norm_ratio, full_scale
   output logic         rsp_tuser,  // reference_found
   output logic         rsp_tlast
);
   import mnhf_pkg::*;

   logic [ValW-1:0] min_ref_ff;
   logic            q_valid, q_ready;
   sample_type      q_data;
   logic [5:0]      oi;
   logic [ValW-1:0] of, os;
   logic [31:0]     orr, ofs;

   always_ff @(posedge clock) begin
      if (reset) min_ref_ff <= '0;
      else if (csr_wr_en) min_ref_ff <= csr_wr_data;
   end

   mnhf_front #(.Points(Points)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_index(req_tdata[7:0]), .in_first(req_tdata[39:8]),
      .in_second(req_tdata[71:40]), .q_valid, .q_ready, .q_data);

   mnhf_back #(.Points(Points)) u_back (
      .clock, .reset, .min_ref(min_ref_ff), .q_valid, .q_ready, .q_data,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_index(oi),
      .out_first(of), .out_second(os), .out_ratio(orr), .out_ref(rsp_tuser),
      .out_fs(ofs), .out_last(rsp_tlast));

   assign rsp_tdata = {4'd0, ofs, orr, os, of, oi};
endmodule
